// ===== hw/rtl/e8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// e8alu_pkg
// Shared types, action codes and flag bit positions for the 8-bit ALU.
// ----------------------------------------------------------------------------
package e8alu_pkg;

  localparam int unsigned ActW = 5;

  localparam logic [ActW-1:0] ACT_ADD = 5'd0;
  localparam logic [ActW-1:0] ACT_ADC = 5'd1;
  localparam logic [ActW-1:0] ACT_SUB = 5'd2;
  localparam logic [ActW-1:0] ACT_SBC = 5'd3;
  localparam logic [ActW-1:0] ACT_AND = 5'd4;
  localparam logic [ActW-1:0] ACT_XOR = 5'd5;
  localparam logic [ActW-1:0] ACT_OR  = 5'd6;
  localparam logic [ActW-1:0] ACT_CP  = 5'd7;
  localparam logic [ActW-1:0] ACT_RLC = 5'd8;
  localparam logic [ActW-1:0] ACT_RRC = 5'd9;
  localparam logic [ActW-1:0] ACT_RL  = 5'd10;
  localparam logic [ActW-1:0] ACT_RR  = 5'd11;
  localparam logic [ActW-1:0] ACT_SLA = 5'd12;
  localparam logic [ActW-1:0] ACT_SRA = 5'd13;
  localparam logic [ActW-1:0] ACT_SLL = 5'd14;
  localparam logic [ActW-1:0] ACT_SRL = 5'd15;
  localparam logic [ActW-1:0] ACT_CPL = 5'd16;
  localparam logic [ActW-1:0] ACT_DAA = 5'd17;

  localparam int unsigned FlgS  = 7;
  localparam int unsigned FlgZ  = 6;
  localparam int unsigned Flg5  = 5;
  localparam int unsigned FlgH  = 4;
  localparam int unsigned Flg3  = 3;
  localparam int unsigned FlgPv = 2;
  localparam int unsigned FlgN  = 1;
  localparam int unsigned FlgC  = 0;

  localparam logic [7:0] DaaLoAdj  = 8'h06;
  localparam logic [7:0] DaaHiAdj  = 8'h60;
  localparam logic [7:0] DaaHiLim  = 8'h99;
  localparam logic [3:0] DaaLoLim  = 4'h9;
  localparam logic [7:0] ByteOnes  = 8'hFF;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [7:0]      operand_a;
    logic [7:0]      operand_b;
    logic [7:0]      flags_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } out_req_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [8:0] sum;
    logic [7:0] src53;
    logic       subtract;
  } arith_req_t;

endpackage

// ===== hw/rtl/e8alu_flags.sv =====
// ----------------------------------------------------------------------------
// e8alu_flags
// Arithmetic flag byte from operands, 9-bit sum and F5/F3 source.
// ----------------------------------------------------------------------------
module e8alu_flags (
  input  e8alu_pkg::arith_req_t req,
  output logic [7:0]            flags
);
  import e8alu_pkg::*;

  logic [7:0] res;
  logic [8:0] hx;
  logic       ovf;

  assign res = req.sum[7:0];
  assign hx  = {1'b0, req.a} ^ {1'b0, req.b} ^ req.sum;
  assign ovf = req.subtract ?
               ((req.a[7] ^ req.b[7]) & (req.a[7] ^ req.sum[7])) :
               (~(req.a[7] ^ req.b[7]) & (req.a[7] ^ req.sum[7]));

  always_comb begin
    flags        = 8'h00;
    flags[FlgS]  = res[7];
    flags[FlgZ]  = (res == 8'h00);
    flags[Flg5]  = req.src53[Flg5];
    flags[Flg3]  = req.src53[Flg3];
    flags[FlgH]  = hx[4];
    flags[FlgPv] = ovf;
    flags[FlgN]  = req.subtract;
    flags[FlgC]  = req.sum[8];
  end

endmodule

// ===== hw/rtl/eight_bit_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Three-stage pipelined 8-bit ALU with Z80-layout flags.
// ----------------------------------------------------------------------------
// A new request is accepted every cycle unless in_stall is high; its
// result is registered through stages 1, 2 and 3. Stage 1 forms the 9-bit
// add/subtract sum and the DAA correction conditions, stage 2 forms the
// arithmetic and compare flag byte, the logic/rotate/shift results and the
// DAA low-nibble correction, stage 3 applies the DAA high correction. Each
// stage holds its contents while the next is full and stalled; in_stall
// rises only when all three stages are occupied and out_stall is high.
module eight_bit_alu_with_flags (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  e8alu_pkg::in_req_t in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output e8alu_pkg::out_req_t out_req
);
  import e8alu_pkg::*;

  logic rdy1, rdy2, rdy3;

  // stage 1
  logic            v1_r;
  logic [ActW-1:0] op1_r;
  logic [7:0]      a1_r, b1_r, f1_r;
  logic [8:0]      sum1_r;
  logic            lo1_r, hi1_r;
  logic [8:0]      sum1_nxt;
  logic            sub1, cin1;

  // stage 2
  logic       v2_r;
  logic [7:0] res2_r, flg2_r;
  logic       hi2_r, neg2_r;
  logic [7:0] res2_nxt, flg2_nxt, daa_t1;
  logic [7:0] arith_flags;
  arith_req_t arith_req;
  logic       cy2;

  // stage 3
  logic       v3_r;
  logic [7:0] res3_r, flg3_r;
  logic [7:0] res3_nxt;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign sub1 = (in_req.action == ACT_SUB) || (in_req.action == ACT_SBC) ||
                (in_req.action == ACT_CP);
  assign cin1 = ((in_req.action == ACT_ADC) || (in_req.action == ACT_SBC)) &&
                in_req.flags_in[FlgC];
  assign sum1_nxt = sub1 ?
    ({1'b0, in_req.operand_a} - {1'b0, in_req.operand_b} - {8'h00, cin1}) :
    ({1'b0, in_req.operand_a} + {1'b0, in_req.operand_b} + {8'h00, cin1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      op1_r  <= in_req.action;
      a1_r   <= in_req.operand_a;
      b1_r   <= in_req.operand_b;
      f1_r   <= in_req.flags_in;
      sum1_r <= sum1_nxt;
      lo1_r  <= in_req.flags_in[FlgH] || (in_req.operand_a[3:0] > DaaLoLim);
      hi1_r  <= in_req.flags_in[FlgC] || (in_req.operand_a > DaaHiLim);
    end
  end

  assign arith_req.a        = a1_r;
  assign arith_req.b        = b1_r;
  assign arith_req.sum      = sum1_r;
  assign arith_req.src53    = (op1_r == ACT_CP) ? b1_r : sum1_r[7:0];
  assign arith_req.subtract = (op1_r == ACT_SUB) || (op1_r == ACT_SBC) ||
                              (op1_r == ACT_CP);

  e8alu_flags u_flags (
    .req   (arith_req),
    .flags (arith_flags)
  );

  assign cy2 = f1_r[FlgC];

  always_comb begin
    if (lo1_r) begin
      daa_t1 = f1_r[FlgN] ? (a1_r - DaaLoAdj) : (a1_r + DaaLoAdj);
    end else begin
      daa_t1 = a1_r;
    end
  end

  always_comb begin
    res2_nxt = a1_r;
    flg2_nxt = f1_r;
    unique case (op1_r)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC: begin
        res2_nxt = sum1_r[7:0];
        flg2_nxt = arith_flags;
      end
      ACT_CP: begin
        res2_nxt = a1_r;
        flg2_nxt = arith_flags;
      end
      ACT_AND: res2_nxt = a1_r & b1_r;
      ACT_XOR: res2_nxt = a1_r ^ b1_r;
      ACT_OR:  res2_nxt = a1_r | b1_r;
      ACT_RLC: res2_nxt = {a1_r[6:0], a1_r[7]};
      ACT_RRC: res2_nxt = {a1_r[0], a1_r[7:1]};
      ACT_RL:  res2_nxt = {a1_r[6:0], cy2};
      ACT_RR:  res2_nxt = {cy2, a1_r[7:1]};
      ACT_SLA: res2_nxt = {a1_r[6:0], 1'b0};
      ACT_SRA: res2_nxt = {a1_r[7], a1_r[7:1]};
      ACT_SLL: res2_nxt = {a1_r[6:0], 1'b1};
      ACT_SRL: res2_nxt = {1'b0, a1_r[7:1]};
      ACT_CPL: res2_nxt = a1_r ^ ByteOnes;
      ACT_DAA: res2_nxt = daa_t1;
      default: res2_nxt = a1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      res2_r <= res2_nxt;
      flg2_r <= flg2_nxt;
      hi2_r  <= (op1_r == ACT_DAA) && hi1_r;
      neg2_r <= f1_r[FlgN];
    end
  end

  always_comb begin
    if (hi2_r) begin
      res3_nxt = neg2_r ? (res2_r - DaaHiAdj) : (res2_r + DaaHiAdj);
    end else begin
      res3_nxt = res2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      res3_r <= res3_nxt;
      flg3_r <= flg2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_req.result    = res3_r;
  assign out_req.flags_out = flg3_r;

endmodule
